[sv/ppct_pkg.sv]
// ---------------------------------------------------------------------------
// Plane collision test package
// Shared constants, shape kinds and register map for the plane versus
// primitive collision test.
// ---------------------------------------------------------------------------
package ppct_pkg;

	localparam int EPSILON_DEF         = 1;
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int NORM_FRAC_BITS      = 14;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		KIND_SPHERE   = 3'd0,
		KIND_LINE     = 3'd1,
		KIND_CAPSULE  = 3'd2,
		KIND_CYLINDER = 3'd3,
		KIND_PLANE    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_PLANE_X  = 3'd0,
		REG_PLANE_Y  = 3'd1,
		REG_PLANE_Z  = 3'd2,
		REG_NORMAL_X = 3'd3,
		REG_NORMAL_Y = 3'd4,
		REG_NORMAL_Z = 3'd5
	} reg_idx_t;

endpackage

[sv/plane_primitive_collision_test.sv]
// ---------------------------------------------------------------------------
// Plane versus primitive collision test
// Six-stage pipeline testing one shape per transfer against a stored plane.
// ---------------------------------------------------------------------------
// Usage:
//   Configure the plane point (Q16.16) and normal (Q2.14) over the APB port
//   at byte addresses 0x00..0x14 while no query is in flight. pready is
//   always high; reads return the stored, sign-extended register value.
//   Queries arrive on req_valid/req_ready with the shape fields; each gives
//   one result transfer on res_valid/res_ready carrying colliding and the
//   saturated signed distance of point A.
//   A query passes six register stages through multiply, sum, round and
//   compare; one query is taken every cycle while the receiver keeps
//   res_ready high.
//   Each stage holds its item when the one after it is full and stalled,
//   so empty stages still fill while a result waits at the output.
//   Reset clears all stage valid bits and loads the plane point with zero
//   and the normal with +z; no clearing pass follows.
// ---------------------------------------------------------------------------
module plane_primitive_collision_test #(
	parameter int EPSILON         = ppct_pkg::EPSILON_DEF,
	parameter int COORD_FRAC_BITS = ppct_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppct_pkg::ADDR_W-1:0]   paddr,
	input  logic [ppct_pkg::DATA_W-1:0]   pwdata,
	output logic [ppct_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [2:0]                    req_type,
	input  logic signed [31:0]            ax,
	input  logic signed [31:0]            ay,
	input  logic signed [31:0]            az,
	input  logic signed [31:0]            bx,
	input  logic signed [31:0]            by,
	input  logic signed [31:0]            bz,
	input  logic [30:0]                   radius,
	input  logic signed [15:0]            other_nx,
	input  logic signed [15:0]            other_ny,
	input  logic signed [15:0]            other_nz,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          colliding,
	output logic signed [31:0]            dist_a
);

	localparam int NF      = ppct_pkg::NORM_FRAC_BITS;
	localparam int PD_W    = 33;
	localparam int PROD_W  = PD_W + 16;
	localparam int RAW_W   = PROD_W + 2;
	localparam int DIST_W  = RAW_W + 1 - NF;
	localparam int EM_W    = 16;
	localparam int ESQ_W   = 2 * EM_W + 2;
	localparam int CSQ_W   = 64;
	localparam int CSUM_W  = CSQ_W + 2;

	localparam logic [63:0] EPS_SQ = 64'(EPSILON) * 64'(EPSILON);
	localparam logic [63:0] E_VAL  = 64'(EPSILON) << (2 * NF - COORD_FRAC_BITS);
	localparam bit          E_OK   = (E_VAL < 64'h0000_0001_0000_0000);
	localparam logic [63:0] E_SQ   = E_VAL * E_VAL;
	localparam logic [RAW_W-1:0] LINE_LIM = RAW_W'(EPSILON) << NF;

	// configuration registers
	logic signed [31:0] ppx_q, ppy_q, ppz_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppx_q <= '0;
			ppy_q <= '0;
			ppz_q <= '0;
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= 16'sd16384;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				ppct_pkg::REG_PLANE_X:  ppx_q <= signed'(pwdata);
				ppct_pkg::REG_PLANE_Y:  ppy_q <= signed'(pwdata);
				ppct_pkg::REG_PLANE_Z:  ppz_q <= signed'(pwdata);
				ppct_pkg::REG_NORMAL_X: nx_q  <= signed'(pwdata[15:0]);
				ppct_pkg::REG_NORMAL_Y: ny_q  <= signed'(pwdata[15:0]);
				ppct_pkg::REG_NORMAL_Z: nz_q  <= signed'(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			ppct_pkg::REG_PLANE_X:  prdata = ppx_q;
			ppct_pkg::REG_PLANE_Y:  prdata = ppy_q;
			ppct_pkg::REG_PLANE_Z:  prdata = ppz_q;
			ppct_pkg::REG_NORMAL_X: prdata = 32'(nx_q);
			ppct_pkg::REG_NORMAL_Y: prdata = 32'(ny_q);
			ppct_pkg::REG_NORMAL_Z: prdata = 32'(nz_q);
			default:                prdata = '0;
		endcase
	end

	// stage valids and flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6      = !valid_s6 || res_ready;
	assign rdy5      = !valid_s5 || rdy6;
	assign rdy4      = !valid_s4 || rdy5;
	assign rdy3      = !valid_s3 || rdy4;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign req_ready = rdy1;
	assign res_valid = valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= req_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
		end
	end

	// stage 1: offsets from the plane point and axis vector
	logic [2:0]                kind_s1;
	logic [30:0]               radius_s1;
	logic signed [15:0]        onx_s1, ony_s1, onz_s1;
	logic signed [PD_W-1:0]    pax_s1, pay_s1, paz_s1;
	logic signed [PD_W-1:0]    pbx_s1, pby_s1, pbz_s1;
	logic signed [PD_W-1:0]    dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			kind_s1   <= req_type;
			radius_s1 <= radius;
			onx_s1    <= other_nx;
			ony_s1    <= other_ny;
			onz_s1    <= other_nz;
			pax_s1    <= PD_W'(ax) - PD_W'(ppx_q);
			pay_s1    <= PD_W'(ay) - PD_W'(ppy_q);
			paz_s1    <= PD_W'(az) - PD_W'(ppz_q);
			pbx_s1    <= PD_W'(bx) - PD_W'(ppx_q);
			pby_s1    <= PD_W'(by) - PD_W'(ppy_q);
			pbz_s1    <= PD_W'(bz) - PD_W'(ppz_q);
			dx_s1     <= PD_W'(bx) - PD_W'(ax);
			dy_s1     <= PD_W'(by) - PD_W'(ay);
			dz_s1     <= PD_W'(bz) - PD_W'(az);
		end
	end

	// stage 2: products with the normal, cross terms, axis magnitudes
	logic [PD_W-1:0] dmx, dmy, dmz;

	assign dmx = dx_s1[PD_W-1] ? PD_W'(-dx_s1) : PD_W'(dx_s1);
	assign dmy = dy_s1[PD_W-1] ? PD_W'(-dy_s1) : PD_W'(dy_s1);
	assign dmz = dz_s1[PD_W-1] ? PD_W'(-dz_s1) : PD_W'(dz_s1);

	logic [2:0]                kind_s2;
	logic [30:0]               radius_s2;
	logic signed [PROD_W-1:0]  pr_ax_s2, pr_ay_s2, pr_az_s2;
	logic signed [PROD_W-1:0]  pr_bx_s2, pr_by_s2, pr_bz_s2;
	logic signed [PROD_W-1:0]  pr_dx_s2, pr_dy_s2, pr_dz_s2;
	logic signed [31:0]        cr_yz_s2, cr_zy_s2, cr_zx_s2, cr_xz_s2, cr_xy_s2, cr_yx_s2;
	logic                      small_s2;
	logic [EM_W-1:0]           em_x_s2, em_y_s2, em_z_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			kind_s2   <= kind_s1;
			radius_s2 <= radius_s1;
			pr_ax_s2  <= PROD_W'(pax_s1) * PROD_W'(nx_q);
			pr_ay_s2  <= PROD_W'(pay_s1) * PROD_W'(ny_q);
			pr_az_s2  <= PROD_W'(paz_s1) * PROD_W'(nz_q);
			pr_bx_s2  <= PROD_W'(pbx_s1) * PROD_W'(nx_q);
			pr_by_s2  <= PROD_W'(pby_s1) * PROD_W'(ny_q);
			pr_bz_s2  <= PROD_W'(pbz_s1) * PROD_W'(nz_q);
			pr_dx_s2  <= PROD_W'(dx_s1) * PROD_W'(nx_q);
			pr_dy_s2  <= PROD_W'(dy_s1) * PROD_W'(ny_q);
			pr_dz_s2  <= PROD_W'(dz_s1) * PROD_W'(nz_q);
			cr_yz_s2  <= 32'(ny_q) * 32'(onz_s1);
			cr_zy_s2  <= 32'(nz_q) * 32'(ony_s1);
			cr_zx_s2  <= 32'(nz_q) * 32'(onx_s1);
			cr_xz_s2  <= 32'(nx_q) * 32'(onz_s1);
			cr_xy_s2  <= 32'(nx_q) * 32'(ony_s1);
			cr_yx_s2  <= 32'(ny_q) * 32'(onx_s1);
			small_s2  <= (dmx <= PD_W'(EPSILON)) && (dmy <= PD_W'(EPSILON)) &&
			             (dmz <= PD_W'(EPSILON));
			em_x_s2   <= dmx[EM_W-1:0];
			em_y_s2   <= dmy[EM_W-1:0];
			em_z_s2   <= dmz[EM_W-1:0];
		end
	end

	// stage 3: dot sums, cross components, axis squares
	logic [2:0]                kind_s3;
	logic [30:0]               radius_s3;
	logic signed [RAW_W-1:0]   raw_a_s3, raw_b_s3, raw_d_s3;
	logic signed [32:0]        cx_s3, cy_s3, cz_s3;
	logic                      small_s3;
	logic [2*EM_W-1:0]         esq_x_s3, esq_y_s3, esq_z_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			kind_s3   <= kind_s2;
			radius_s3 <= radius_s2;
			raw_a_s3  <= RAW_W'(pr_ax_s2) + RAW_W'(pr_ay_s2) + RAW_W'(pr_az_s2);
			raw_b_s3  <= RAW_W'(pr_bx_s2) + RAW_W'(pr_by_s2) + RAW_W'(pr_bz_s2);
			raw_d_s3  <= RAW_W'(pr_dx_s2) + RAW_W'(pr_dy_s2) + RAW_W'(pr_dz_s2);
			cx_s3     <= 33'(cr_yz_s2) - 33'(cr_zy_s2);
			cy_s3     <= 33'(cr_zx_s2) - 33'(cr_xz_s2);
			cz_s3     <= 33'(cr_xy_s2) - 33'(cr_yx_s2);
			small_s3  <= small_s2;
			esq_x_s3  <= (2*EM_W)'(em_x_s2) * (2*EM_W)'(em_x_s2);
			esq_y_s3  <= (2*EM_W)'(em_y_s2) * (2*EM_W)'(em_y_s2);
			esq_z_s3  <= (2*EM_W)'(em_z_s2) * (2*EM_W)'(em_z_s2);
		end
	end

	// stage 4: rounding to coordinate units, parallel test, cross squares
	logic signed [RAW_W:0]     rnd_a, rnd_b;
	logic [RAW_W-1:0]          dmag;
	logic [32:0]               cmx, cmy, cmz;
	logic [ESQ_W-1:0]          esq_sum;

	assign rnd_a   = (RAW_W+1)'(raw_a_s3) + (RAW_W+1)'(1 << (NF - 1));
	assign rnd_b   = (RAW_W+1)'(raw_b_s3) + (RAW_W+1)'(1 << (NF - 1));
	assign dmag    = raw_d_s3[RAW_W-1] ? RAW_W'(-raw_d_s3) : RAW_W'(raw_d_s3);
	assign cmx     = cx_s3[32] ? 33'(-cx_s3) : 33'(cx_s3);
	assign cmy     = cy_s3[32] ? 33'(-cy_s3) : 33'(cy_s3);
	assign cmz     = cz_s3[32] ? 33'(-cz_s3) : 33'(cz_s3);
	assign esq_sum = ESQ_W'(esq_x_s3) + ESQ_W'(esq_y_s3) + ESQ_W'(esq_z_s3);

	logic [2:0]                kind_s4;
	logic [30:0]               radius_s4;
	logic signed [DIST_W-1:0]  da_s4, db_s4;
	logic                      line_cross_s4;
	logic [CSQ_W-1:0]          csq_x_s4, csq_y_s4, csq_z_s4;
	logic                      degen_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			kind_s4       <= kind_s3;
			radius_s4     <= radius_s3;
			da_s4         <= signed'(rnd_a[RAW_W:NF]);
			db_s4         <= signed'(rnd_b[RAW_W:NF]);
			line_cross_s4 <= dmag > LINE_LIM;
			csq_x_s4      <= CSQ_W'(cmx[31:0]) * CSQ_W'(cmx[31:0]);
			csq_y_s4      <= CSQ_W'(cmy[31:0]) * CSQ_W'(cmy[31:0]);
			csq_z_s4      <= CSQ_W'(cmz[31:0]) * CSQ_W'(cmz[31:0]);
			degen_s4      <= small_s3 && (esq_sum <= ESQ_W'(EPS_SQ));
		end
	end

	// stage 5: distance compares, plane cross test, saturation
	logic [DIST_W-1:0]         mag_a, mag_b;
	logic [CSUM_W-1:0]         csum;
	logic                      a_fits;

	assign mag_a  = da_s4[DIST_W-1] ? DIST_W'(-da_s4) : DIST_W'(da_s4);
	assign mag_b  = db_s4[DIST_W-1] ? DIST_W'(-db_s4) : DIST_W'(db_s4);
	assign csum   = CSUM_W'(csq_x_s4) + CSUM_W'(csq_y_s4) + CSUM_W'(csq_z_s4);
	assign a_fits = (da_s4[DIST_W-1:31] == '0) || (da_s4[DIST_W-1:31] == '1);

	logic [2:0]                kind_s5;
	logic                      a_in_r_s5, b_in_r_s5, a_eps_s5, b_eps_s5, opp_s5;
	logic                      line_cross_s5, plane_cross_s5, degen_s5;
	logic signed [31:0]        dsat_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			kind_s5        <= kind_s4;
			a_in_r_s5      <= mag_a <= DIST_W'(radius_s4);
			b_in_r_s5      <= mag_b <= DIST_W'(radius_s4);
			a_eps_s5       <= mag_a <= DIST_W'(EPSILON);
			b_eps_s5       <= mag_b <= DIST_W'(EPSILON);
			opp_s5         <= (da_s4[DIST_W-1] && !db_s4[DIST_W-1] && (db_s4 != '0)) ||
			                  (db_s4[DIST_W-1] && !da_s4[DIST_W-1] && (da_s4 != '0));
			line_cross_s5  <= line_cross_s4;
			plane_cross_s5 <= E_OK && (csum > CSUM_W'(E_SQ));
			degen_s5       <= degen_s4;
			if (a_fits)
				dsat_s5 <= da_s4[31:0];
			else if (da_s4[DIST_W-1])
				dsat_s5 <= 32'sh8000_0000;
			else
				dsat_s5 <= 32'sh7fff_ffff;
		end
	end

	// stage 6: per-kind decision into the output register
	logic hit;

	always_comb begin
		case (kind_s5)
			ppct_pkg::KIND_SPHERE:   hit = a_in_r_s5;
			ppct_pkg::KIND_LINE:     hit = a_eps_s5 || b_eps_s5 || line_cross_s5;
			ppct_pkg::KIND_CAPSULE,
			ppct_pkg::KIND_CYLINDER: hit = degen_s5 ? a_in_r_s5 :
			                               (a_in_r_s5 || b_in_r_s5 || opp_s5);
			ppct_pkg::KIND_PLANE:    hit = plane_cross_s5 || a_eps_s5;
			default:                 hit = 1'b0;
		endcase
	end

	logic               colliding_s6;
	logic signed [31:0] dist_s6;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			colliding_s6 <= hit;
			dist_s6      <= dsat_s5;
		end
	end

	assign colliding = colliding_s6;
	assign dist_a    = dist_s6;

endmodule

[sv/ppct_checker.sv]
// ---------------------------------------------------------------------------
// Plane collision test port checker
// Port-level properties of the collision test, bound to the top level.
// ---------------------------------------------------------------------------
module ppct_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [ppct_pkg::ADDR_W-1:0] paddr,
	input logic [ppct_pkg::DATA_W-1:0] pwdata,
	input logic [ppct_pkg::DATA_W-1:0] prdata,
	input logic                        pready,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        colliding,
	input logic signed [31:0]          dist_a
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(colliding) && $stable(dist_a))
		else $error("result changed while stalled");

	// with the receiver ready, an accepted request comes out as a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 res_ready ##1 res_ready ##1 res_ready
		##1 res_ready ##1 res_ready |=> res_valid)
		else $error("result transfer missing after pipeline latency");

	// plane point x register write reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[4:2] == ppct_pkg::REG_PLANE_X)
		|=> (paddr[4:2] != ppct_pkg::REG_PLANE_X) || (prdata == $past(pwdata)))
		else $error("plane point x readback mismatch");

	// no result while in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result valid during reset");

endmodule

bind plane_primitive_collision_test ppct_checker u_ppct_checker (.*);

[tb/tb_plane_primitive_collision_test.sv]
// ---------------------------------------------------------------------------
// Plane collision test bench
// Drives shape queries into the plane collision pipeline and checks colliding
// and the saturated distance of A against an in-bench integer predictor.
// The APB registers are written and read back, then swept through several
// planes, extremes included, with random idling and output hold-offs.
// ---------------------------------------------------------------------------
module tb_plane_primitive_collision_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int EPSILON         = ppct_pkg::EPSILON_DEF;
	localparam int COORD_FRAC_BITS = ppct_pkg::COORD_FRAC_BITS_DEF;
	localparam longint I32_MAX     = 64'sd2147483647;
	localparam longint I32_MIN     = -64'sd2147483648;
	localparam logic [2:0] KIND_FIRST_SPARE = 3'd5;

	typedef struct {
		logic [2:0]         kind;
		logic signed [31:0] ax, ay, az, bx, by, bz;
		logic [30:0]        radius;
		logic signed [15:0] onx, ony, onz;
	} query_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] dist_val;
	} verdict_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel, penable, pwrite;
	logic [ppct_pkg::ADDR_W-1:0]   paddr;
	logic [ppct_pkg::DATA_W-1:0]   pwdata;
	logic [ppct_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          req_valid;
	logic                          req_ready;
	logic [2:0]                    req_type;
	logic signed [31:0]            ax, ay, az, bx, by, bz;
	logic [30:0]                   radius;
	logic signed [15:0]            other_nx, other_ny, other_nz;
	logic                          res_valid;
	logic                          res_ready = 1'b0;
	logic                          colliding;
	logic signed [31:0]            dist_a;

	longint   plane_pt[3];
	longint   plane_nrm[3];
	verdict_t expected_verdicts[$];
	int       fault_count = 0;
	bit       idle_on = 1'b1;
	int       hold_len = 0;
	int       hold_asked = 0;
	int       hold_served = 0;
	int       hold_left = 0;

	plane_primitive_collision_test #(
		.EPSILON(EPSILON),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.ax(ax),
		.ay(ay),
		.az(az),
		.bx(bx),
		.by(by),
		.bz(bz),
		.radius(radius),
		.other_nx(other_nx),
		.other_ny(other_ny),
		.other_nz(other_nz),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.colliding(colliding),
		.dist_a(dist_a)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#(2_000_000);
		$display("FAIL");
		$finish;
	end

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// signed distance in coordinate LSBs, rounded half up
	function automatic longint dist_of(longint x, longint y, longint z);
		longint raw;
		raw = (x - plane_pt[0]) * plane_nrm[0] + (y - plane_pt[1]) * plane_nrm[1] +
			(z - plane_pt[2]) * plane_nrm[2];
		return (raw + (longint'(1) <<< (ppct_pkg::NORM_FRAC_BITS - 1))) >>>
			ppct_pkg::NORM_FRAC_BITS;
	endfunction

	function automatic verdict_t predict_verdict(query_t q);
		longint   da, db, lean, r, eps, dx, dy, dz, cx, cy, cz, sat;
		logic [63:0] cross_sq, eps_c;
		logic     hit;
		verdict_t v;
		eps = EPSILON;
		r   = longint'(q.radius);
		da  = dist_of(q.ax, q.ay, q.az);
		db  = dist_of(q.bx, q.by, q.bz);
		dx  = longint'(q.bx) - longint'(q.ax);
		dy  = longint'(q.by) - longint'(q.ay);
		dz  = longint'(q.bz) - longint'(q.az);
		case (q.kind)
			ppct_pkg::KIND_SPHERE: hit = mag(da) <= r;
			ppct_pkg::KIND_LINE: begin
				if (mag(da) <= eps || mag(db) <= eps) begin
					hit = 1'b1;
				end else begin
					lean = plane_nrm[0] * dx + plane_nrm[1] * dy + plane_nrm[2] * dz;
					hit  = mag(lean) > (eps <<< ppct_pkg::NORM_FRAC_BITS);
				end
			end
			ppct_pkg::KIND_CAPSULE, ppct_pkg::KIND_CYLINDER: begin
				if (mag(dx) <= eps && mag(dy) <= eps && mag(dz) <= eps &&
					dx * dx + dy * dy + dz * dz <= eps * eps) begin
					hit = mag(da) <= r;
				end else begin
					hit = mag(da) <= r || mag(db) <= r || (da < 0 && db > 0) ||
						(da > 0 && db < 0);
				end
			end
			ppct_pkg::KIND_PLANE: begin
				cx = plane_nrm[1] * longint'(q.onz) - plane_nrm[2] * longint'(q.ony);
				cy = plane_nrm[2] * longint'(q.onx) - plane_nrm[0] * longint'(q.onz);
				cz = plane_nrm[0] * longint'(q.ony) - plane_nrm[1] * longint'(q.onx);
				cross_sq = cx * cx + cy * cy + cz * cz;
				eps_c = 64'(EPSILON) << (2 * ppct_pkg::NORM_FRAC_BITS - COORD_FRAC_BITS);
				hit = (eps_c < (64'd1 << 32) && cross_sq > eps_c * eps_c) ||
					mag(da) <= eps;
			end
			default: hit = 1'b0;
		endcase
		sat = da;
		if (sat > I32_MAX) sat = I32_MAX;
		if (sat < I32_MIN) sat = I32_MIN;
		v.hit      = hit;
		v.dist_val = 32'(sat);
		return v;
	endfunction

	function automatic void flag_mismatch(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%t mismatch: %s", $realtime, msg);
	endfunction

	// transfer monitor: predict on request, compare on result
	always @(posedge clk) begin : watch
		query_t   seen;
		verdict_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				seen.kind   = req_type;
				seen.ax     = ax;
				seen.ay     = ay;
				seen.az     = az;
				seen.bx     = bx;
				seen.by     = by;
				seen.bz     = bz;
				seen.radius = radius;
				seen.onx    = other_nx;
				seen.ony    = other_ny;
				seen.onz    = other_nz;
				expected_verdicts.push_back(predict_verdict(seen));
			end
			if (res_valid && res_ready) begin
				if (expected_verdicts.size() == 0) begin
					flag_mismatch($sformatf("unexpected result colliding=%0b dist_a=%0d",
						colliding, dist_a));
				end else begin
					want = expected_verdicts.pop_front();
					if (colliding !== want.hit)
						flag_mismatch($sformatf("colliding exp %0b got %0b",
							want.hit, colliding));
					if (dist_a !== want.dist_val)
						flag_mismatch($sformatf("dist_a exp %0d got %0d",
							want.dist_val, dist_a));
				end
			end
		end
	end

	// result side: random stalls plus requested long hold-offs
	always @(posedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left   = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= !(idle_on && $urandom_range(99) < 11);
		end
	end

	task automatic write_reg(ppct_pkg::reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ppct_pkg::ADDR_W'(4 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx <= ppct_pkg::REG_PLANE_Z)
			plane_pt[int'(idx)] = longint'(signed'(value));
		else
			plane_nrm[int'(idx) - int'(ppct_pkg::REG_NORMAL_X)] =
				longint'(signed'(value[15:0]));
		@(posedge clk);
	endtask

	task automatic send_query(query_t q);
		while (idle_on && $urandom_range(99) < 11) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= q.kind;
		ax        <= q.ax;
		ay        <= q.ay;
		az        <= q.az;
		bx        <= q.bx;
		by        <= q.by;
		bz        <= q.bz;
		radius    <= q.radius;
		other_nx  <= q.onx;
		other_ny  <= q.ony;
		other_nz  <= q.onz;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic finish_burst();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_verdicts.size() != 0);
	endtask

	function automatic query_t shape(logic [2:0] kind, longint a_z, longint b_z,
		longint r);
		query_t q;
		q        = '{default: '0};
		q.kind   = kind;
		q.az     = 32'(a_z);
		q.bz     = 32'(b_z);
		q.radius = 31'(r);
		return q;
	endfunction

	function automatic logic signed [31:0] pick_coord(int axis);
		logic signed [31:0] base;
		base = 32'(plane_pt[axis]);
		case ($urandom_range(9))
			0, 1: return $urandom();
			2: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return base;
					default: return -32'sd1;
				endcase
			end
			3: return base + 32'($urandom_range(8)) - 32'sd4;
			default: return base + 32'($urandom_range(524288)) - 32'sd262144;
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		int     pick;
		longint k, r;
		longint p[3];
		q.ax     = pick_coord(0);
		q.ay     = pick_coord(1);
		q.az     = pick_coord(2);
		q.bx     = pick_coord(0);
		q.by     = pick_coord(1);
		q.bz     = pick_coord(2);
		q.onx    = 16'($urandom());
		q.ony    = 16'($urandom());
		q.onz    = 16'($urandom());
		pick = $urandom_range(99);
		if (pick < 18)      q.kind = ppct_pkg::KIND_SPHERE;
		else if (pick < 36) q.kind = ppct_pkg::KIND_LINE;
		else if (pick < 54) q.kind = ppct_pkg::KIND_CAPSULE;
		else if (pick < 72) q.kind = ppct_pkg::KIND_CYLINDER;
		else if (pick < 92) q.kind = ppct_pkg::KIND_PLANE;
		else                q.kind = KIND_FIRST_SPARE + 3'($urandom_range(2));
		case (q.kind)
			ppct_pkg::KIND_LINE: begin
				// direction perpendicular to the normal, jittered across the parallel bound
				if ($urandom_range(2) != 0) begin
					case ($urandom_range(2))
						0: p = '{0, plane_nrm[2], -plane_nrm[1]};
						1: p = '{-plane_nrm[2], 0, plane_nrm[0]};
						default: p = '{plane_nrm[1], -plane_nrm[0], 0};
					endcase
					k = longint'($urandom_range(1, 3));
					if ($urandom_range(1) != 0) k = -k;
					q.bx = q.ax + 32'(k * p[0] + longint'($urandom_range(2)) - 1);
					q.by = q.ay + 32'(k * p[1] + longint'($urandom_range(2)) - 1);
					q.bz = q.az + 32'(k * p[2] + longint'($urandom_range(2)) - 1);
				end
			end
			ppct_pkg::KIND_CAPSULE, ppct_pkg::KIND_CYLINDER: begin
				if ($urandom_range(3) == 0) begin
					q.bx = q.ax + 32'(longint'($urandom_range(2)) - 1);
					q.by = q.ay + 32'(longint'($urandom_range(2)) - 1);
					q.bz = q.az + 32'(longint'($urandom_range(2)) - 1);
				end
			end
			ppct_pkg::KIND_PLANE: begin
				case ($urandom_range(4))
					0: begin
						q.onx = 16'(plane_nrm[0]);
						q.ony = 16'(plane_nrm[1]);
						q.onz = 16'(plane_nrm[2]);
					end
					1: begin
						q.onx = 16'(-plane_nrm[0]);
						q.ony = 16'(-plane_nrm[1]);
						q.onz = 16'(-plane_nrm[2]);
					end
					2: begin
						q.onx = 16'(plane_nrm[0] + longint'($urandom_range(16)) - 8);
						q.ony = 16'(plane_nrm[1] + longint'($urandom_range(16)) - 8);
						q.onz = 16'(plane_nrm[2] + longint'($urandom_range(16)) - 8);
					end
					3: begin
						q.onx = 16'(int'($urandom_range(32768)) - 16384);
						q.ony = 16'(int'($urandom_range(32768)) - 16384);
						q.onz = 16'(int'($urandom_range(32768)) - 16384);
					end
					default: ;
				endcase
				if ($urandom_range(2) == 0) begin
					q.ax = 32'(plane_pt[0] + longint'($urandom_range(4)) - 2);
					q.ay = 32'(plane_pt[1] + longint'($urandom_range(4)) - 2);
					q.az = 32'(plane_pt[2] + longint'($urandom_range(4)) - 2);
				end
			end
			default: ;
		endcase
		// radius: full range, small, zero, maximum, or on the edge of either end's distance
		case ($urandom_range(5))
			0: r = longint'(31'($urandom()));
			1: r = longint'($urandom_range(65536));
			2: r = mag(dist_of(q.ax, q.ay, q.az)) + longint'($urandom_range(2)) - 1;
			3: r = mag(dist_of(q.bx, q.by, q.bz)) + longint'($urandom_range(2)) - 1;
			4: r = 0;
			default: r = I32_MAX;
		endcase
		if (r < 0) r = 0;
		if (r > I32_MAX) r = I32_MAX;
		q.radius = 31'(r);
		return q;
	endfunction

	task automatic load_plane(logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] pz, logic signed [15:0] nx, logic signed [15:0] ny,
		logic signed [15:0] nz);
		write_reg(ppct_pkg::REG_PLANE_X, px);
		write_reg(ppct_pkg::REG_PLANE_Y, py);
		write_reg(ppct_pkg::REG_PLANE_Z, pz);
		write_reg(ppct_pkg::REG_NORMAL_X, 32'(nx));
		write_reg(ppct_pkg::REG_NORMAL_Y, 32'(ny));
		write_reg(ppct_pkg::REG_NORMAL_Z, 32'(nz));
	endtask

	task automatic run_phase(logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] pz, logic signed [15:0] nx, logic signed [15:0] ny,
		logic signed [15:0] nz, int count);
		load_plane(px, py, pz, nx, ny, nz);
		repeat (count) send_query(random_query());
		finish_burst();
	endtask

	task automatic test_register_access();
		logic [31:0]        values[3];
		logic [31:0]        want, got;
		ppct_pkg::reg_idx_t idx;
		for (int i = 0; i <= int'(ppct_pkg::REG_NORMAL_Z); i++) begin
			idx = ppct_pkg::reg_idx_t'(i);
			if (idx <= ppct_pkg::REG_PLANE_Z)
				values = '{32'h8000_0000, 32'h7fff_ffff, $urandom()};
			else
				values = '{32'hffff_8000, 32'h0000_7fff, $urandom()};
			foreach (values[v]) begin
				write_reg(idx, values[v]);
				want = (idx <= ppct_pkg::REG_PLANE_Z) ? values[v] :
					32'(signed'(values[v][15:0]));
				psel    <= 1'b1;
				penable <= 1'b0;
				pwrite  <= 1'b0;
				paddr   <= ppct_pkg::ADDR_W'(4 * i);
				@(posedge clk);
				penable <= 1'b1;
				do @(posedge clk); while (!pready);
				got = prdata;
				psel    <= 1'b0;
				penable <= 1'b0;
				@(posedge clk);
				if (got !== want)
					flag_mismatch($sformatf("register %0d read exp %h got %h", i, want, got));
			end
		end
		load_plane(0, 0, 0, 0, 0, 16'sd16384);
	endtask

	// plane at the origin, normal +z: dist(p) is simply p.z
	task automatic test_directed_cases();
		query_t q;
		send_query(shape(ppct_pkg::KIND_SPHERE, 5, 0, 5));
		send_query(shape(ppct_pkg::KIND_SPHERE, -5, 0, 4));
		q = shape(ppct_pkg::KIND_SPHERE, 0, 0, 0);
		q.ax = 32'sh7fff_ffff; q.ay = 32'sh7fff_ffff; q.az = 32'sh7fff_ffff;
		q.radius = '1;
		send_query(q);
		q = shape(ppct_pkg::KIND_SPHERE, 0, 0, 0);
		q.ax = 32'sh8000_0000; q.ay = 32'sh8000_0000; q.az = 32'sh8000_0000;
		send_query(q);
		send_query(shape(ppct_pkg::KIND_SPHERE, 0, 0, 0));
		send_query(shape(ppct_pkg::KIND_LINE, 1, 1000, 0));
		send_query(shape(ppct_pkg::KIND_LINE, 2, -1, 0));
		q = shape(ppct_pkg::KIND_LINE, 2, 2, 0);
		q.bx = 32'sd65536;
		send_query(q);
		send_query(shape(ppct_pkg::KIND_LINE, 2, 3, 0));
		send_query(shape(ppct_pkg::KIND_LINE, 2, 4, 0));
		// degenerate axis ignores B even though B is within the radius
		q = shape(ppct_pkg::KIND_CAPSULE, 10, 9, 9);
		send_query(q);
		q.bx = 32'sd1;
		send_query(q);
		send_query(shape(ppct_pkg::KIND_CAPSULE, 100, -100, 0));
		send_query(shape(ppct_pkg::KIND_CAPSULE, 100, 200, 99));
		send_query(shape(ppct_pkg::KIND_CYLINDER, 50, 60, 49));
		send_query(shape(ppct_pkg::KIND_CYLINDER, 50, 60, 50));
		send_query(shape(ppct_pkg::KIND_CYLINDER, -3, -3, 3));
		send_query(shape(ppct_pkg::KIND_CYLINDER, -1, 1, 0));
		q = shape(ppct_pkg::KIND_PLANE, 1, 0, 0);
		q.onz = 16'sd16384;
		send_query(q);
		q = shape(ppct_pkg::KIND_PLANE, 2, 0, 0);
		q.onz = -16'sd16384;
		send_query(q);
		q = shape(ppct_pkg::KIND_PLANE, 1000, 0, 0);
		q.onx = 16'sd16384;
		send_query(q);
		for (int i = 0; i < 3; i++)
			send_query(shape(KIND_FIRST_SPARE + 3'(i), 0, 0, 0));
		finish_burst();
	endtask

	task automatic test_plane_sweep();
		run_phase(0, 0, 0, 0, 0, 16'sd16384, 75);
		run_phase($urandom(), $urandom(), $urandom(), 16'sd16384, 0, 0, 75);
		run_phase(32'($urandom_range(2000000)) - 32'sd1000000,
			32'($urandom_range(2000000)) - 32'sd1000000,
			32'($urandom_range(2000000)) - 32'sd1000000,
			16'sd11585, -16'sd11585, 0, 75);
		run_phase($urandom(), $urandom(), $urandom(),
			16'(int'($urandom_range(32768)) - 16384),
			16'(int'($urandom_range(32768)) - 16384),
			16'(int'($urandom_range(32768)) - 16384), 75);
		run_phase(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			16'sh8000, 16'sh7fff, 16'sh8000, 75);
		run_phase(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			16'sd16384, 16'sd16384, 16'sd16384, 75);
		run_phase(0, 0, 0, 0, 0, 0, 40);
	endtask

	task automatic test_output_backpressure();
		load_plane($urandom(), $urandom(), $urandom(), 0, -16'sd16384, 0);
		hold_len = 150;
		hold_asked++;
		repeat (30) send_query(random_query());
		// sender stops until the pipeline has emptied, then resumes
		finish_burst();
		repeat (10) send_query(random_query());
		finish_burst();
		repeat (10) send_query(random_query());
		finish_burst();
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		run_phase($urandom(), $urandom(), $urandom(),
			16'(int'($urandom_range(32768)) - 16384), 16'sd9459, 16'sd9459, 100);
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		req_type  = ppct_pkg::KIND_SPHERE;
		ax        = '0;
		ay        = '0;
		az        = '0;
		bx        = '0;
		by        = '0;
		bz        = '0;
		radius    = '0;
		other_nx  = '0;
		other_ny  = '0;
		other_nz  = '0;
		plane_pt  = '{0, 0, 0};
		plane_nrm = '{0, 0, longint'(1) <<< ppct_pkg::NORM_FRAC_BITS};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_cases();
		test_plane_sweep();
		test_output_backpressure();
		test_steady_stream();

		finish_burst();
		repeat (10) @(posedge clk);
		if (fault_count == 0 && expected_verdicts.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[plane_primitive_collision_test.f]
sv/ppct_pkg.sv
sv/plane_primitive_collision_test.sv
sv/ppct_checker.sv
tb/tb_plane_primitive_collision_test.sv
